[sv/adaptive_threshold_heart_rate_macros.svh]
// Assertion shorthands for the RTL datapath; each expects clk and arst_n in scope.
`ifndef ADAPTIVE_THRESHOLD_HEART_RATE_MACROS_SVH
`define ADAPTIVE_THRESHOLD_HEART_RATE_MACROS_SVH

// Same-cycle implication.
`define ATR_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ATR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/atr_pkg.sv]
package atr_pkg;

	localparam int SMP_W  = 18;
	localparam int TIME_W = 32;
	localparam int BPM_W  = 16;
	localparam int MEAN_W = 8;

	localparam int WIN_INIT    = 7000;
	localparam int MS_PER_MIN  = 60000;
	localparam int RATE_LOW    = 20;
	localparam int RATE_HIGH   = 255;

	// rate stored iff RATE_LOW < 60000/delta < RATE_HIGH
	localparam int DELTA_MIN = MS_PER_MIN / RATE_HIGH + 1;
	localparam int DELTA_MAX = (MS_PER_MIN - 1) / RATE_LOW;

	localparam logic [BPM_W-1:0] BPM_SAT = '1;

	// serial divider for 60000 / interval
	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	typedef enum logic [1:0] {
		NOTE_NONE  = 2'd0,
		NOTE_MEAN  = 2'd1,
		NOTE_WRIST = 2'd2
	} note_t;

	typedef struct packed {
		logic     capture;
		logic     win_upd;
		logic     take_avg;
		logic     take_thr;
		logic     div_start;
		logic     wrist;
		logic     sat_bpm;
		logic     beat_time;
		logic     take_bpm;
		logic     ring_wr;
		logic     take_mean;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic above;
		logic beat;
		logic delta_zero;
		logic rate_ok;
		logic out_free;
	} stat_t;

endpackage

[sv/atr_ctrl.sv]
module atr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  atr_pkg::stat_t stat,
	output atr_pkg::cmd_t  cmd
);
	import atr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_AVG,
		S_THR,
		S_EVAL,
		S_BPM_W,
		S_MEAN,
		S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.capture = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				cmd.win_upd = 1'b1;
				state_d     = S_AVG;
			end
			S_AVG: begin
				cmd.take_avg = 1'b1;
				state_d      = S_THR;
			end
			S_THR: begin
				cmd.take_thr = 1'b1;
				state_d      = S_EVAL;
			end
			S_EVAL: begin
				if (!stat.above) begin
					cmd.wrist = 1'b1;
					state_d   = S_OUT;
				end else if (!stat.beat) begin
					state_d = S_OUT;
				end else if (stat.delta_zero) begin
					cmd.sat_bpm   = 1'b1;
					cmd.beat_time = 1'b1;
					state_d       = S_OUT;
				end else begin
					cmd.beat_time = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = S_BPM_W;
				end
			end
			S_BPM_W: begin
				if (stat.div_done) begin
					cmd.take_bpm = 1'b1;
					if (stat.rate_ok) begin
						cmd.ring_wr = 1'b1;
						state_d     = S_MEAN;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_MEAN: begin
				cmd.take_mean = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == S_IDLE);
		end
	end

endmodule

[sv/atr_dp.sv]
module atr_dp #(
	parameter int WINDOW_DEPTH = 100,
	parameter int RATE_DEPTH   = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [atr_pkg::SMP_W-1:0]    ir_sample,
	input  logic [atr_pkg::TIME_W-1:0]   time_ms,
	input  logic                         beat_detected,
	input  atr_pkg::cmd_t                cmd,
	output atr_pkg::stat_t               stat,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [atr_pkg::SMP_W-1:0]    threshold,
	output logic                         above_threshold,
	output logic [atr_pkg::BPM_W-1:0]    instant_bpm,
	output logic [atr_pkg::MEAN_W-1:0]   average_bpm,
	output atr_pkg::note_t               notify
);
	import atr_pkg::*;

`include "adaptive_threshold_heart_rate_macros.svh"

	localparam int SUM_W  = SMP_W + $clog2(WINDOW_DEPTH);
	localparam int POS_W  = $clog2(WINDOW_DEPTH);
	localparam int RPOS_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
	localparam int TOT_W  = MEAN_W + $clog2(RATE_DEPTH);
	localparam logic [SUM_W-1:0] SUM_INIT = SUM_W'(WIN_INIT * WINDOW_DEPTH);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_DEPTH - 1);
	localparam logic [RPOS_W-1:0] RPOS_LAST = RPOS_W'(RATE_DEPTH - 1);

	// floor(n / d) for a w-bit n as (n * ceil(2^s / d)) >> s, s = w + clog2(d); exact
	localparam int THR_DEN = 5;

	localparam int     AVG_SH  = SUM_W + POS_W;
	localparam int     AVG_M_W = SUM_W + 1;
	localparam int     AVG_P_W = SUM_W + AVG_M_W;
	localparam longint AVG_M_L = ((longint'(1) << AVG_SH) + longint'(WINDOW_DEPTH) - 1) /
		longint'(WINDOW_DEPTH);
	localparam logic [AVG_M_W-1:0] AVG_M = AVG_M_W'(AVG_M_L);

	localparam int     THR_N_W = SMP_W + 2;
	localparam int     THR_SH  = THR_N_W + $clog2(THR_DEN);
	localparam int     THR_M_W = THR_N_W + 1;
	localparam int     THR_P_W = THR_N_W + THR_M_W;
	localparam longint THR_M_L = ((longint'(1) << THR_SH) + longint'(THR_DEN) - 1) /
		longint'(THR_DEN);
	localparam logic [THR_M_W-1:0] THR_M = THR_M_W'(THR_M_L);

	localparam int     MEAN_SH  = TOT_W + $clog2(RATE_DEPTH);
	localparam int     MEAN_M_W = TOT_W + 1;
	localparam int     MEAN_P_W = TOT_W + MEAN_M_W;
	localparam longint MEAN_M_L = ((longint'(1) << MEAN_SH) + longint'(RATE_DEPTH) - 1) /
		longint'(RATE_DEPTH);
	localparam logic [MEAN_M_W-1:0] MEAN_M = MEAN_M_W'(MEAN_M_L);

	// captured transaction
	logic [SMP_W-1:0]  smp_q;
	logic [TIME_W-1:0] time_q;
	logic              beat_q;

	// sample window
	logic [SMP_W-1:0] win_mem [WINDOW_DEPTH];
	logic [SMP_W-1:0] win_rd_q;
	logic [SMP_W-1:0] win_old;
	logic [POS_W-1:0] pos_q;
	logic             filled_q;
	logic [SUM_W-1:0] sum_q;

	// constant divisions
	logic [AVG_P_W-1:0]  avg_prod;
	logic [SMP_W-1:0]    avg_q;
	logic [THR_P_W-1:0]  thr_prod;
	logic [SMP_W-1:0]    thr_w;
	logic [MEAN_P_W-1:0] mean_prod;

	// rate state
	logic [MEAN_W-1:0] ring_q [RATE_DEPTH];
	logic [RPOS_W-1:0] rpos_q;
	logic [TOT_W-1:0]  tot_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] delta_w;
	logic              rate_ok_q;
	logic [BPM_W-1:0]  bpm_now_q;
	logic [MEAN_W-1:0] mean_q;
	logic              armed_q;
	logic [SMP_W-1:0]  thr_q;
	logic              above_q;
	note_t             note_q;

	// divider
	logic [DIV_W-1:0]     div_rem_q;
	logic [DIV_W-1:0]     div_quo_q;
	logic [DIV_W-1:0]     div_dsr_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DIV_W:0]       div_sh;
	logic                 div_ge;
	logic [DIV_W:0]       div_sub;
	logic                 div_done_w;

	// output register
	logic              out_valid_q;
	logic [SMP_W-1:0]  out_thr_q;
	logic              out_above_q;
	logic [BPM_W-1:0]  out_bpm_q;
	logic [MEAN_W-1:0] out_mean_q;
	note_t             out_note_q;

	assign win_old    = filled_q ? win_rd_q : SMP_W'(WIN_INIT);
	assign delta_w    = time_q - last_q;
	assign div_done_w = (div_cnt_q == '0);

	assign stat.div_done   = div_done_w;
	assign stat.above      = above_q;
	assign stat.beat       = beat_q;
	assign stat.delta_zero = (delta_w == '0);
	assign stat.rate_ok    = rate_ok_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	// window mean, four fifths of it, ring mean
	assign avg_prod  = AVG_P_W'(sum_q) * AVG_P_W'(AVG_M);
	assign thr_prod  = THR_P_W'({avg_q, 2'b00}) * THR_P_W'(THR_M);
	assign thr_w     = thr_prod[THR_SH +: SMP_W];
	assign mean_prod = MEAN_P_W'(tot_q) * MEAN_P_W'(MEAN_M);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q  <= ir_sample;
			time_q <= time_ms;
			beat_q <= beat_detected;
		end
		if (cmd.win_upd) begin
			win_mem[pos_q] <= smp_q;
		end
		win_rd_q <= win_mem[pos_q];
	end

	// restoring divider, one quotient bit a cycle; 60000 left-aligned, 16 bits iterated
	assign div_sh  = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge  = (div_sh >= {1'b0, div_dsr_q});
	assign div_sub = div_sh - {1'b0, div_dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DIV_CNT_W'(BPM_W);
		end else if (!div_done_w) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= {BPM_W'(MS_PER_MIN), {(DIV_W - BPM_W){1'b0}}};
			div_dsr_q <= delta_w;
		end else if (!div_done_w) begin
			div_rem_q <= div_ge ? div_sub[DIV_W-1:0] : div_sh[DIV_W-1:0];
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			filled_q  <= 1'b0;
			sum_q     <= SUM_INIT;
			avg_q     <= '0;
			rpos_q    <= '0;
			tot_q     <= '0;
			last_q    <= '0;
			rate_ok_q <= 1'b0;
			bpm_now_q <= '0;
			mean_q    <= '0;
			armed_q   <= 1'b1;
			thr_q     <= '0;
			above_q   <= 1'b0;
			note_q    <= NOTE_NONE;
			for (int i = 0; i < RATE_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				note_q <= NOTE_NONE;
			end
			if (cmd.win_upd) begin
				sum_q <= sum_q - SUM_W'(win_old) + SUM_W'(smp_q);
				if (pos_q == POS_LAST) begin
					pos_q    <= '0;
					filled_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (cmd.take_avg) begin
				avg_q <= avg_prod[AVG_SH +: SMP_W];
			end
			if (cmd.take_thr) begin
				thr_q   <= thr_w;
				above_q <= (smp_q > thr_w);
			end
			if (cmd.wrist) begin
				bpm_now_q <= '0;
				mean_q    <= '0;
				if (armed_q) begin
					note_q  <= NOTE_WRIST;
					armed_q <= 1'b0;
				end
			end
			if (cmd.beat_time) begin
				last_q    <= time_q;
				rate_ok_q <= (delta_w >= TIME_W'(DELTA_MIN)) &&
					(delta_w <= TIME_W'(DELTA_MAX));
			end
			if (cmd.sat_bpm) begin
				bpm_now_q <= BPM_SAT;
			end
			if (cmd.take_bpm) begin
				bpm_now_q <= div_quo_q[BPM_W-1:0];
			end
			if (cmd.ring_wr) begin
				ring_q[rpos_q] <= div_quo_q[MEAN_W-1:0];
				tot_q <= tot_q - TOT_W'(ring_q[rpos_q]) + TOT_W'(div_quo_q[MEAN_W-1:0]);
				rpos_q <= (rpos_q == RPOS_LAST) ? '0 : rpos_q + 1'b1;
			end
			if (cmd.take_mean) begin
				mean_q <= mean_prod[MEAN_SH +: MEAN_W];
				note_q <= NOTE_MEAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_thr_q   <= thr_q;
			out_above_q <= above_q;
			out_bpm_q   <= bpm_now_q;
			out_mean_q  <= mean_q;
			out_note_q  <= note_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign threshold       = out_thr_q;
	assign above_threshold = out_above_q;
	assign instant_bpm     = out_bpm_q;
	assign average_bpm     = out_mean_q;
	assign notify          = out_note_q;

	`ATR_ASSERT_HOLDS(a_div_idle_start, cmd.div_start, div_done_w, "divider restarted while busy")
	`ATR_ASSERT_NEXT(a_notice_once, !armed_q, !armed_q, "no-wrist notice re-armed")
	`ATR_ASSERT_HOLDS(a_wrist_below, out_valid_q && (out_note_q == NOTE_WRIST), !out_above_q, "no-wrist notice above threshold")
	`ATR_ASSERT_HOLDS(a_mean_note, out_valid_q && (out_note_q == NOTE_MEAN), out_above_q && (out_mean_q != '0), "mean notice without a stored rate")

endmodule

[sv/adaptive_threshold_heart_rate.sv]
// Heart-rate averager with an adaptive wrist threshold. Each input transaction carries one
// infrared sample, its millisecond time and a beat flag from an external detector; each
// produces exactly one result transaction. The sample replaces the oldest entry of a
// WINDOW_DEPTH-deep window (initially all 7000) and the threshold is four fifths of the
// floored window mean. A beat on a sample above the threshold gives 60000 / interval as
// the instant rate (65535 for a zero interval); rates strictly between 20 and 255 enter a
// RATE_DEPTH-deep ring whose mean is reported with notify = 1. A sample at or below the
// threshold clears both rates, and the first such sample after reset reports notify = 2.
// Items are handled one at a time. The window mean, the threshold and the ring mean come
// from constant-reciprocal multiplications; only 60000 / interval runs on a serial divider
// producing one quotient bit per cycle, and that divider sets the worst case. A result not
// yet taken holds the sequencer in its hand-off state until it is. The result sits in an
// output register, so a new transaction can be accepted while it waits to be taken.
// The window lives in a single-port memory; entries not yet written read as 7000 by means
// of a first-lap flag, so no clearing pass follows reset.
module adaptive_threshold_heart_rate #(
	parameter int WINDOW_DEPTH = 100,
	parameter int RATE_DEPTH   = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [atr_pkg::SMP_W-1:0]    ir_sample,
	input  logic [atr_pkg::TIME_W-1:0]   time_ms,
	input  logic                         beat_detected,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [atr_pkg::SMP_W-1:0]    threshold,
	output logic                         above_threshold,
	output logic [atr_pkg::BPM_W-1:0]    instant_bpm,
	output logic [atr_pkg::MEAN_W-1:0]   average_bpm,
	output logic [1:0]                   notify
);
	import atr_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	note_t note_w;

	// sequencer: walks window update, mean and threshold, the rate division, the ring mean
	// and the result hand-off
	atr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// window, constant divisions, rate divider, rate ring and output register
	atr_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.RATE_DEPTH   (RATE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ir_sample       (ir_sample),
		.time_ms         (time_ms),
		.beat_detected   (beat_detected),
		.cmd             (cmd),
		.stat            (stat),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.threshold       (threshold),
		.above_threshold (above_threshold),
		.instant_bpm     (instant_bpm),
		.average_bpm     (average_bpm),
		.notify          (note_w)
	);

	assign notify = note_w;

endmodule

[sim/adaptive_threshold_heart_rate_tb.sv]
`timescale 1ns / 1ps

module adaptive_threshold_heart_rate_tb;

	import atr_pkg::*;

	// Block configuration under test; the DUT is built with its default depths.
	localparam int WIN_N      = 100;
	localparam int RING_N     = 4;
	localparam int SMP_MAX    = (1 << SMP_W) - 1;
	localparam logic [SMP_W-1:0] SMP_FULL = '1;
	localparam int HOLD_TICKS = 600;
	localparam int TAIL_TICKS = 120;	// well over the slowest item latency
	localparam int LIMIT      = 1000000;

	// One input transaction.
	typedef struct packed {
		logic [SMP_W-1:0]  sample;
		logic [TIME_W-1:0] stamp;
		logic              beat;
	} hr_sample_t;

	// One result transaction.
	typedef struct packed {
		logic [SMP_W-1:0]  thr;
		logic              above;
		logic [BPM_W-1:0]  inst;
		logic [MEAN_W-1:0] mean;
		note_t             note;
	} hr_result_t;

	// Everything the block remembers between transactions.
	typedef struct packed {
		logic [WIN_N-1:0][SMP_W-1:0]   win;
		logic [31:0]                   sum;
		logic [6:0]                    wpos;
		logic [RING_N-1:0][MEAN_W-1:0] ring;
		logic [1:0]                    rpos;
		logic [TIME_W-1:0]             last_beat;
		logic [BPM_W-1:0]              bpm_now;
		logic [MEAN_W-1:0]             bpm_mean;
		logic                          armed;
	} hr_state_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [SMP_W-1:0]  ir_sample     = '0;
	logic [TIME_W-1:0] time_ms       = '0;
	logic              beat_detected = 1'b0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic [SMP_W-1:0]  threshold;
	logic              above_threshold;
	logic [BPM_W-1:0]  instant_bpm;
	logic [MEAN_W-1:0] average_bpm;
	logic [1:0]        notify;

	adaptive_threshold_heart_rate #(
		.WINDOW_DEPTH (WIN_N),
		.RATE_DEPTH   (RING_N)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.ir_sample       (ir_sample),
		.time_ms         (time_ms),
		.beat_detected   (beat_detected),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.threshold       (threshold),
		.above_threshold (above_threshold),
		.instant_bpm     (instant_bpm),
		.average_bpm     (average_bpm),
		.notify          (notify)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Behavioural model of the averager
	// ------------------------------------------------------------------

	function automatic hr_state_t power_on_state();
		hr_state_t s;
		s = '0;
		for (int i = 0; i < WIN_N; i++)
			s.win[i] = SMP_W'(WIN_INIT);
		s.sum   = 32'(WIN_INIT * WIN_N);
		s.armed = 1'b1;
		return s;
	endfunction

	// Threshold the block would report if smp went into the window next.
	function automatic logic [SMP_W-1:0] threshold_after(hr_state_t s, logic [SMP_W-1:0] smp);
		longint total;
		total = s.sum;
		total = total - s.win[s.wpos] + smp;
		return SMP_W'((total / WIN_N) * 4 / 5);
	endfunction

	// Advances the state by one sample and gives the reading it produces.
	task automatic heart_rate_step(inout hr_state_t st, input hr_sample_t smp,
			output hr_result_t res);
		logic [TIME_W-1:0] delta;
		logic [31:0]       quot;
		longint            d;
		int                total;
		res       = '0;
		res.thr   = threshold_after(st, smp.sample);
		st.sum    = st.sum - st.win[st.wpos] + smp.sample;
		st.win[st.wpos] = smp.sample;
		st.wpos   = (st.wpos == WIN_N - 1) ? '0 : st.wpos + 1'b1;
		res.above = smp.sample > res.thr;
		res.note  = NOTE_NONE;
		if (res.above) begin
			if (smp.beat) begin
				delta        = smp.stamp - st.last_beat;	// wraps like the counter
				st.last_beat = smp.stamp;
				if (delta == '0) begin
					st.bpm_now = BPM_SAT;
				end else begin
					quot       = 32'(MS_PER_MIN) / delta;
					st.bpm_now = quot[BPM_W-1:0];
					d          = delta;
					// exact quotient strictly inside the plausible band
					if (MS_PER_MIN < RATE_HIGH * d && MS_PER_MIN > RATE_LOW * d) begin
						st.ring[st.rpos] = quot[MEAN_W-1:0];
						st.rpos = (st.rpos == RING_N - 1) ? '0 : st.rpos + 1'b1;
						total = 0;
						for (int i = 0; i < RING_N; i++)
							total += st.ring[i];
						st.bpm_mean = MEAN_W'(total / RING_N);
						res.note    = NOTE_MEAN;
					end
				end
			end
		end else begin
			// no wrist: rates dropped, notice only on the first dropout after reset
			if (st.armed) begin
				res.note = NOTE_WRIST;
				st.armed = 1'b0;
			end
			st.bpm_now  = '0;
			st.bpm_mean = '0;
		end
		res.inst = st.bpm_now;
		res.mean = st.bpm_mean;
	endtask

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------

	hr_sample_t samples_to_send[$];
	hr_result_t readings_due[$];
	hr_state_t  plan;	// generator's look-ahead copy, used to aim at the threshold
	hr_state_t  model;	// advanced only on accepted transactions
	int         offered;
	int         level = 50000;	// current signal level of the simulated wrist
	int         send_idle_pct;
	int         recv_stall_pct;
	logic       hold_req;

	task automatic offer(logic [SMP_W-1:0] smp, logic [TIME_W-1:0] stamp, logic beat);
		hr_sample_t item;
		hr_result_t unused;
		item = '{sample: smp, stamp: stamp, beat: beat};
		samples_to_send.push_back(item);
		heart_rate_step(plan, item, unused);
		offered++;
	endtask

	// A sample sitting on (or within a count of) its own threshold.
	function automatic logic [SMP_W-1:0] tie_sample(hr_state_t s);
		logic [SMP_W-1:0] v;
		v = threshold_after(s, '0);
		repeat (6)
			v = threshold_after(s, v);
		return v;
	endfunction

	function automatic logic [SMP_W-1:0] near_level();
		int v;
		v = level * 9 / 10 + int'($urandom_range(0, level / 5));
		return (v > SMP_MAX) ? SMP_W'(SMP_MAX) : SMP_W'(v);
	endfunction

	// Steady pulse train: level drifts a little, beats at a jittered plausible interval,
	// a few plain samples in between.
	task automatic queue_rhythm();
		int beats;
		int gaps;
		int ival;
		int span;
		logic [TIME_W-1:0] t0;
		level = level * int'($urandom_range(85, 125)) / 100;
		if (level < 500)
			level = 500;
		if (level > SMP_MAX)
			level = SMP_MAX;
		ival  = $urandom_range(DELTA_MIN, DELTA_MAX);
		beats = $urandom_range(4, 20);
		for (int b = 0; b < beats; b++) begin
			span = ival - ival / 20 + int'($urandom_range(0, ival / 10));
			gaps = $urandom_range(0, 3);
			t0   = plan.last_beat;
			for (int g = 1; g <= gaps; g++)
				offer(near_level(), t0 + TIME_W'(span * g / (gaps + 1)), 1'b0);
			offer(near_level(), t0 + TIME_W'(span), 1'b1);
		end
	endtask

	// Broken pulse trains and boundary intervals.
	task automatic queue_glitch();
		case ($urandom_range(0, 6))
			0: offer(near_level(), plan.last_beat, 1'b1);
			1: offer(near_level(), plan.last_beat + $urandom_range(1, DELTA_MIN - 1), 1'b1);
			2: offer(near_level(), plan.last_beat + $urandom_range(DELTA_MAX + 1, 200000), 1'b1);
			3: offer(near_level(), plan.last_beat + $urandom, 1'b1);
			4: begin
				repeat ($urandom_range(1, 6))
					offer(SMP_W'($urandom_range(0, level / 2)),
						plan.last_beat + $urandom_range(1, 3000), 1'($urandom_range(0, 1)));
			end
			5: begin
				offer(tie_sample(plan), plan.last_beat + 500, 1'b1);
				offer(tie_sample(plan) + 1'b1, plan.last_beat + 500, 1'b1);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: offer(near_level(), plan.last_beat + DELTA_MIN - 1, 1'b1);
					1: offer(near_level(), plan.last_beat + DELTA_MIN, 1'b1);
					2: offer(near_level(), plan.last_beat + DELTA_MAX, 1'b1);
					default: offer(near_level(), plan.last_beat + DELTA_MAX + 1, 1'b1);
				endcase
			end
		endcase
	endtask

	task automatic queue_random(int n);
		int stop;
		int pick;
		stop = offered + n;
		while (offered < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_rhythm();
			end else if (pick < 85) begin
				queue_glitch();
			end else begin
				// raw noise, and now and then a jump to an unrelated level
				repeat ($urandom_range(1, 4))
					offer(SMP_W'($urandom_range(0, SMP_MAX)), $urandom, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 3) == 0)
					level = $urandom_range(1000, SMP_MAX);
			end
		end
	endtask

	// Sender parks until the queue is empty and every reading has come back.
	task automatic drain();
		while (samples_to_send.size() != 0 || in_valid || readings_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int n);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		queue_random(n);
		drain();
	endtask

	// ------------------------------------------------------------------
	// Driver: one sample transaction at a time from samples_to_send
	// ------------------------------------------------------------------

	hr_sample_t on_offer;
	int         accepted;

	always @(posedge clk or negedge arst_n) begin
		hr_result_t due;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				heart_rate_step(model, on_offer, due);
				readings_due.push_back(due);
				accepted++;
			end
			// payload stays put until the transaction goes through
			if (!in_valid || in_ready) begin
				if (samples_to_send.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					on_offer      = samples_to_send.pop_front();
					in_valid      <= 1'b1;
					ir_sample     <= on_offer.sample;
					time_ms       <= on_offer.stamp;
					beat_detected <= on_offer.beat;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver back-pressure, including one long hold-off
	// ------------------------------------------------------------------

	int   hold_left;
	logic hold_taken;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_left  <= HOLD_TICKS;
			hold_taken <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each result transaction against the oldest reading due
	// ------------------------------------------------------------------

	int failures;
	int results_seen;
	int rate_notes;
	int wrist_notes;
	int dropouts;

	always @(posedge clk or negedge arst_n) begin
		hr_result_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (readings_due.size() == 0) begin
					$error("result transaction with no reading due");
					failures++;
				end else begin
					due = readings_due.pop_front();
					if (threshold !== due.thr) begin
						$error("threshold: expected %0d, got %0d", due.thr, threshold);
						failures++;
					end
					if (above_threshold !== due.above) begin
						$error("above_threshold: expected %0d, got %0d", due.above,
							above_threshold);
						failures++;
					end
					if (instant_bpm !== due.inst) begin
						$error("instant_bpm: expected %0d, got %0d", due.inst, instant_bpm);
						failures++;
					end
					if (average_bpm !== due.mean) begin
						$error("average_bpm: expected %0d, got %0d", due.mean, average_bpm);
						failures++;
					end
					if (notify !== due.note) begin
						$error("notify: expected %0d, got %0d", due.note, notify);
						failures++;
					end
					if (due.note == NOTE_MEAN)
						rate_notes++;
					if (due.note == NOTE_WRIST)
						wrist_notes++;
					if (!due.above)
						dropouts++;
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog.
	int cycles;

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------

	initial begin
		plan           = power_on_state();
		model          = power_on_state();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: dropout first (one no-wrist notice, beat ignored), then full-scale
		// samples walking the interval through every edge of the rate band.
		offer('0, '0, 1'b1);
		offer('0, 5, 1'b0);
		offer(SMP_FULL, 1000, 1'b1);
		offer(SMP_FULL, 1000, 1'b1);							// zero interval saturates
		offer(SMP_FULL, plan.last_beat + DELTA_MIN, 1'b1);		// fastest stored rate
		offer(SMP_FULL, plan.last_beat + DELTA_MIN - 1, 1'b1);	// just too fast
		offer(SMP_FULL, plan.last_beat + DELTA_MAX, 1'b1);		// slowest stored rate
		offer(SMP_FULL, plan.last_beat + DELTA_MAX + 1, 1'b1);	// just too slow
		offer(SMP_FULL, plan.last_beat + 1, 1'b1);				// one millisecond
		offer(SMP_FULL, '1, 1'b0);								// above, no beat
		offer(SMP_FULL, 32'hFFFF_FF00, 1'b1);					// huge interval, rate 0
		offer(SMP_FULL, 32'h0000_0100, 1'b1);					// interval across the wrap
		repeat (4)
			offer(SMP_FULL, plan.last_beat + 500, 1'b1);		// fill the ring
		offer(tie_sample(plan), plan.last_beat + 500, 1'b1);	// on the threshold
		offer(tie_sample(plan) + 1'b1, plan.last_beat + 500, 1'b1);	// ring kept
		offer(SMP_W'(1), plan.last_beat + 7, 1'b0);
		drain();

		// Random phases across the idling patterns.
		run_phase(0, 0, 450);
		run_phase(54, 0, 450);
		run_phase(0, 54, 450);
		run_phase(19, 19, 450);

		// Back-pressure: the receiver holds off while the sender keeps offering,
		// so the block fills up and drops in_ready.
		@(negedge clk);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		queue_random(80);
		drain();

		repeat (TAIL_TICKS) @(negedge clk);

		$display("Sent %0d samples and checked %0d readings in %0d cycles.",
			accepted, results_seen, cycles);
		$display("Readings: %0d new averages, %0d no-wrist notices, %0d below threshold.",
			rate_notes, wrist_notes, dropouts);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/atr_pkg.sv
sv/atr_ctrl.sv
sv/atr_dp.sv
sv/adaptive_threshold_heart_rate.sv
sim/adaptive_threshold_heart_rate_tb.sv
